>>> rtl/core/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg: shared types for the line rasteriser
// Transaction payloads and the command and status groups that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int FIELD_COORD_W = 6;
  localparam int COLOR_W       = 4;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] start_x;
    logic [FIELD_COORD_W-1:0] start_y;
    logic [FIELD_COORD_W-1:0] end_x;
    logic [FIELD_COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]       line_color;
  } line_cmd_t;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] pixel_x;
    logic [FIELD_COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     last_pixel;
  } pixel_t;

  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/blr_if.sv
// ----------------------------------------------------------------------------
// blr_if: channel interfaces
// Valid/ready channels for line commands and for pixels.
// ----------------------------------------------------------------------------
interface line_cmd_if;
  logic               valid;
  logic               ready;
  blr_pkg::line_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pixel_if;
  logic            valid;
  logic            ready;
  blr_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: Bresenham line rasteriser, top level
// Turns each line command into its pixels, first endpoint first.
// ----------------------------------------------------------------------------
// A line command with major-axis delta D produces D + 1 pixels. The set-up
// for a command is loaded when the command is taken, then the single stepper
// issues one pixel per cycle, which is the limit on throughput. The next
// command is taken as soon as the final pixel has moved into the output
// register. Stalls on the pixel channel hold the stepper.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input logic        clk,
  input logic        rst,
  line_cmd_if.sink   cmd,
  pixel_if.source    pix
);
  import blr_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  blr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .status    (status),
    .dp_cmd    (dp_cmd)
  );

  blr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .dp_cmd   (dp_cmd),
    .status   (status),
    .cmd_data (cmd.data),
    .pix      (pix)
  );

endmodule

>>> rtl/core/blr_ctrl.sv
// ----------------------------------------------------------------------------
// blr_ctrl: line rasteriser controller
// Accepts a line command when idle, then sequences the stepper one pixel per
// free output slot until the final pixel has been issued.
// ----------------------------------------------------------------------------
module blr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  blr_pkg::dp_status_t status,
  output blr_pkg::dp_cmd_t    dp_cmd
);
  import blr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd_ready   = 1'b0;
    dp_cmd.load = 1'b0;
    dp_cmd.emit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          dp_cmd.emit = 1'b1;
          if (status.last_step) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/blr_datapath.sv
// ----------------------------------------------------------------------------
// blr_datapath: line rasteriser stepper and output register
// Holds the line set-up, the Bresenham error term and the current position,
// and registers each issued pixel towards the output channel.
// ----------------------------------------------------------------------------
module blr_datapath #(
  parameter int COORD_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  blr_pkg::dp_cmd_t    dp_cmd,
  output blr_pkg::dp_status_t status,
  input  blr_pkg::line_cmd_t  cmd_data,
  pixel_if.source             pix
);
  import blr_pkg::*;

  localparam int EW = COORD_BITS + 3;

  logic [COORD_BITS-1:0] cur_x, cur_y, steps, major, minor;
  logic [EW-1:0]         err;
  logic                  sxn, syn, xmaj;
  logic [COLOR_W-1:0]    color;
  logic                  out_valid;
  pixel_t                out_data;

  logic [COORD_BITS-1:0] x0, y0, x1, y1, adx, ady, major_n, minor_n;
  logic                  sxn_n, syn_n, xmaj_n;
  logic [EW-1:0]         err_init, two_minor, two_major, err_step;
  logic                  err_ge;
  logic [COORD_BITS-1:0] x_inc, y_inc;

  assign x0 = cmd_data.start_x[COORD_BITS-1:0];
  assign y0 = cmd_data.start_y[COORD_BITS-1:0];
  assign x1 = cmd_data.end_x[COORD_BITS-1:0];
  assign y1 = cmd_data.end_y[COORD_BITS-1:0];

  always_comb begin
    sxn_n    = x1 < x0;
    syn_n    = y1 < y0;
    adx      = sxn_n ? (x0 - x1) : (x1 - x0);
    ady      = syn_n ? (y0 - y1) : (y1 - y0);
    xmaj_n   = adx > ady;
    major_n  = xmaj_n ? adx : ady;
    minor_n  = xmaj_n ? ady : adx;
    err_init = (EW'(minor_n) << 1) - EW'(major_n);
  end

  always_comb begin
    two_minor = EW'(minor) << 1;
    two_major = EW'(major) << 1;
    err_ge    = !err[EW-1];
    err_step  = err_ge ? (err + two_minor - two_major) : (err + two_minor);
    x_inc     = sxn ? (cur_x - 1'b1) : (cur_x + 1'b1);
    y_inc     = syn ? (cur_y - 1'b1) : (cur_y + 1'b1);
  end

  assign status.last_step = (steps == '0);
  assign status.out_free  = !out_valid || pix.ready;

  assign pix.valid = out_valid;
  assign pix.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      err   <= '0;
      steps <= '0;
      major <= '0;
      minor <= '0;
      sxn   <= 1'b0;
      syn   <= 1'b0;
      xmaj  <= 1'b0;
      color <= '0;
    end else if (dp_cmd.load) begin
      cur_x <= x0;
      cur_y <= y0;
      err   <= err_init;
      steps <= major_n;
      major <= major_n;
      minor <= minor_n;
      sxn   <= sxn_n;
      syn   <= syn_n;
      xmaj  <= xmaj_n;
      color <= cmd_data.line_color;
    end else if (dp_cmd.emit) begin
      err   <= err_step;
      steps <= steps - 1'b1;
      if (xmaj) begin
        cur_x <= x_inc;
        if (err_ge) begin
          cur_y <= y_inc;
        end
      end else begin
        cur_y <= y_inc;
        if (err_ge) begin
          cur_x <= x_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_data.pixel_x     <= FIELD_COORD_W'(cur_x);
      out_data.pixel_y     <= FIELD_COORD_W'(cur_y);
      out_data.pixel_color <= color;
      out_data.last_pixel  <= (steps == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the Bresenham line rasteriser
// Line commands are driven from a queue through the command channel, each
// accepted command is traced in software into the pixels it should yield,
// and every pixel transaction is checked in order against those pixels. Both
// channels idle at random, apart from one long stretch without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import blr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_LINES = 500;
  localparam int IDLE_PERCENT = 18;
  localparam int END_CYCLES   = 70;

  logic clk = 1'b0;
  logic rst = 1'b1;

  line_cmd_if cmd_ch ();
  pixel_if    pix_ch ();

  line_cmd_t pending_lines[$];
  pixel_t    expected_pixels[$];
  int        errors      = 0;
  int        cycles      = 0;
  int        lines_taken = 0;
  bit        cmd_taken   = 1'b0;
  logic      calm;

  bresenham_line_rasterizer #(
    .COORD_BITS(FIELD_COORD_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .pix (pix_ch)
  );

  always #10 clk = ~clk;

  assign calm = (lines_taken >= 200) && (lines_taken < 300);

  function automatic line_cmd_t make_line(input int x0, input int y0, input int x1,
                                          input int y1, input int colour);
    line_cmd_t c;
    c.start_x    = x0[FIELD_COORD_W-1:0];
    c.start_y    = y0[FIELD_COORD_W-1:0];
    c.end_x      = x1[FIELD_COORD_W-1:0];
    c.end_y      = y1[FIELD_COORD_W-1:0];
    c.line_color = colour[COLOR_W-1:0];
    return c;
  endfunction

  function automatic int nudge(input int v);
    int n;
    n = v + int'($urandom_range(0, 6)) - 3;
    if (n < 0) n = 0;
    if (n > 63) n = 63;
    return n;
  endfunction

  // Steps along the major axis and appends every pixel of the line to the
  // queue of expected pixels, first endpoint first.
  function automatic void trace_line(input line_cmd_t c);
    logic [FIELD_COORD_W-1:0] cx, cy, adx, ady, major, minor, steps;
    logic                     sx_neg, sy_neg, x_major;
    int                       err;
    pixel_t                   p;
    sx_neg  = c.end_x < c.start_x;
    sy_neg  = c.end_y < c.start_y;
    adx     = sx_neg ? c.start_x - c.end_x : c.end_x - c.start_x;
    ady     = sy_neg ? c.start_y - c.end_y : c.end_y - c.start_y;
    x_major = adx > ady;
    major   = x_major ? adx : ady;
    minor   = x_major ? ady : adx;
    err     = 2 * int'(minor) - int'(major);
    steps   = major;
    cx      = c.start_x;
    cy      = c.start_y;
    p.pixel_color = c.line_color;
    forever begin
      p.pixel_x    = cx;
      p.pixel_y    = cy;
      p.last_pixel = (steps == 0);
      expected_pixels.push_back(p);
      if (steps == 0) break;
      if (err >= 0) begin
        if (x_major) cy = sy_neg ? cy - 1'b1 : cy + 1'b1;
        else cx = sx_neg ? cx - 1'b1 : cx + 1'b1;
        err += 2 * (int'(minor) - int'(major));
      end else begin
        err += 2 * int'(minor);
      end
      if (x_major) cx = sx_neg ? cx - 1'b1 : cx + 1'b1;
      else cy = sy_neg ? cy - 1'b1 : cy + 1'b1;
      steps = steps - 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bresenham_line_rasterizer: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    cmd_taken = !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d last=%0d", $time,
                 pix_ch.data.pixel_x, pix_ch.data.pixel_y, pix_ch.data.pixel_color,
                 pix_ch.data.last_pixel);
      end else begin
        want = expected_pixels.pop_front();
        if (pix_ch.data.pixel_x !== want.pixel_x || pix_ch.data.pixel_y !== want.pixel_y ||
            pix_ch.data.pixel_color !== want.pixel_color ||
            pix_ch.data.last_pixel !== want.last_pixel) begin
          errors++;
          $display("%0t: expected x=%0d y=%0d colour=%0d last=%0d, got x=%0d y=%0d colour=%0d last=%0d",
                   $time, want.pixel_x, want.pixel_y, want.pixel_color, want.last_pixel,
                   pix_ch.data.pixel_x, pix_ch.data.pixel_y, pix_ch.data.pixel_color,
                   pix_ch.data.last_pixel);
        end
      end
    end
    if (cmd_taken) begin
      trace_line(cmd_ch.data);
      lines_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
      pix_ch.ready <= 1'b0;
    end else begin
      if (!cmd_ch.valid || cmd_taken) begin
        if (pending_lines.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          cmd_ch.data  <= pending_lines.pop_front();
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
      pix_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin
    int x0, y0, x1, y1, d, mode;

    pending_lines.push_back(make_line(0, 0, 0, 0, 0));
    pending_lines.push_back(make_line(63, 63, 63, 63, 15));
    pending_lines.push_back(make_line(0, 0, 63, 0, 5));
    pending_lines.push_back(make_line(63, 0, 0, 0, 10));
    pending_lines.push_back(make_line(0, 0, 0, 63, 3));
    pending_lines.push_back(make_line(0, 63, 0, 0, 12));
    pending_lines.push_back(make_line(0, 0, 63, 63, 1));
    pending_lines.push_back(make_line(63, 63, 0, 0, 2));
    pending_lines.push_back(make_line(0, 63, 63, 0, 4));
    pending_lines.push_back(make_line(63, 0, 0, 63, 8));
    pending_lines.push_back(make_line(10, 10, 40, 20, 6));
    pending_lines.push_back(make_line(40, 20, 10, 10, 7));
    pending_lines.push_back(make_line(10, 20, 40, 10, 9));
    pending_lines.push_back(make_line(40, 10, 10, 20, 3));
    pending_lines.push_back(make_line(5, 5, 12, 40, 11));
    pending_lines.push_back(make_line(12, 40, 5, 5, 13));
    pending_lines.push_back(make_line(5, 40, 12, 5, 14));
    pending_lines.push_back(make_line(12, 5, 5, 40, 1));
    pending_lines.push_back(make_line(20, 20, 21, 22, 15));
    pending_lines.push_back(make_line(20, 20, 22, 21, 0));
    pending_lines.push_back(make_line(30, 30, 31, 31, 5));
    pending_lines.push_back(make_line(0, 0, 1, 0, 15));
    pending_lines.push_back(make_line(42, 21, 21, 42, 10));

    // Mostly unrestricted lines, with diagonal ties, axis-aligned lines,
    // single points and very short lines mixed in.
    repeat (RANDOM_LINES) begin
      mode = $urandom_range(0, 9);
      x0 = $urandom_range(0, 63);
      y0 = $urandom_range(0, 63);
      x1 = $urandom_range(0, 63);
      y1 = $urandom_range(0, 63);
      case (mode)
        6: begin
          d  = $urandom_range(0, 31);
          x1 = (x0 >= 32) ? x0 - d : x0 + d;
          y1 = (y0 >= 32) ? y0 - d : y0 + d;
        end
        7: begin
          if ($urandom_range(0, 1)) x1 = x0;
          else y1 = y0;
        end
        8: begin
          x1 = x0;
          y1 = y0;
        end
        9: begin
          x1 = nudge(x0);
          y1 = nudge(y0);
        end
        default: ;
      endcase
      pending_lines.push_back(make_line(x0, y0, x1, y1, $urandom_range(0, 15)));
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_lines.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("bresenham_line_rasterizer: match");
    end else begin
      $display("bresenham_line_rasterizer: mismatch");
    end
    $finish;
  end

endmodule
